>>> design/ptt_pkg.sv
// Shared types, codes and constants of the pending transaction timeout table.
// Used by the cell, the core and the checker.
package ptt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int MAX_RESULTS         = 16;
  localparam int EXP_CNT_W           = $clog2(MAX_RESULTS);

  localparam logic [30:0] TIMEOUT_RESET = 31'd1000;

  localparam logic [1:0] ACT_POST     = 2'd0;
  localparam logic [1:0] ACT_COMPLETE = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  localparam logic [2:0] STATUS_POSTED    = 3'd0;
  localparam logic [2:0] STATUS_FULL      = 3'd1;
  localparam logic [2:0] STATUS_COMPLETED = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_TIMED_OUT = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] tag;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> design/ptt_req_if.sv
// Request channel of the pending transaction timeout table.
// Depends on nothing.
interface ptt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] trans_id;
  logic [15:0] user_tag;
  logic [31:0] payload_ref;

  modport source (output valid, action, trans_id, user_tag, payload_ref, input ready);
  modport sink (input valid, action, trans_id, user_tag, payload_ref, output ready);
endinterface

>>> design/ptt_rsp_if.sv
// Result channel of the pending transaction timeout table.
// Depends on nothing.
interface ptt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_id;
  logic [15:0] out_tag;
  logic [31:0] out_payload;
  logic        has_payload;
  logic        last;

  modport source (output valid, status, out_id, out_tag, out_payload, has_payload, last,
                  input ready);
  modport sink (input valid, status, out_id, out_tag, out_payload, has_payload, last,
                output ready);
endinterface

>>> design/ptt_cfg_if.sv
// Configuration write channel carrying the timeout register value.
// Depends on nothing.
interface ptt_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

>>> design/ptt_cell.sv
// One table cell: holds one outstanding entry, loads a new one or takes its
// neighbor's entry, and compares its id against the search key. Uses ptt_pkg.
module ptt_cell (
  input  logic                clk,
  input  ptt_pkg::cell_ctrl_t ctrl,
  input  ptt_pkg::entry_t     load_data,
  input  ptt_pkg::entry_t     nbr,
  input  logic [31:0]         key,
  output ptt_pkg::entry_t     entry,
  output logic                match
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= nbr;
    end else if (ctrl.load) begin
      entry <= load_data;
    end
  end

  assign match = (entry.id == key);

endmodule

>>> design/pending_transaction_timeout_table_core.sv
// Tracks up to TABLE_DEPTH outstanding transactions in a chain of cells, oldest in cell 0.
// A post or a complete is accepted (ids are compared in every cell in that cycle) and its
// single result is loaded into the output register once that register is free.
// A tick expires the entries past their deadline, at most 16 per tick; the chain shifts out
// one entry per cycle into the one result register while that register is free, and stalls
// while it still holds an untaken result. Entries never written are never read.
module pending_transaction_timeout_table_core #(
  parameter int TABLE_DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH
) (
  input logic         clk,
  input logic         rst,
  ptt_cfg_if.sink     cfg,
  ptt_req_if.sink     req,
  ptt_rsp_if.source   rsp
);

  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_EXPIRE} state_t;

  state_t                       state;
  logic [OCC_W-1:0]             occ;
  logic [31:0]                  tick_count;
  logic [30:0]                  timeout;
  logic [ptt_pkg::EXP_CNT_W-1:0] exp_cnt;
  logic [1:0]                   act_q;
  logic [31:0]                  id_q;
  logic [15:0]                  tag_q;
  logic [31:0]                  pay_q;
  logic [TABLE_DEPTH-1:0]       match_q;
  logic                         rsp_valid;

  ptt_pkg::entry_t     cell_entry [TABLE_DEPTH];
  ptt_pkg::cell_ctrl_t cell_ctrl  [TABLE_DEPTH];
  ptt_pkg::entry_t     new_entry;
  logic [TABLE_DEPTH-1:0] match_now, live, first, tail_mask, shift_vec, load_vec;
  logic [15:0] sel_tag;
  logic [31:0] diff0, diff1;
  logic exp0, exp1, found, full, out_free, do_post, do_remove, do_expire, exp_last;
  logic rsp_load;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == TABLE_DEPTH - 1) begin : g_end
        ptt_cell u_cell (
          .clk(clk), .ctrl(cell_ctrl[g]), .load_data(new_entry), .nbr(cell_entry[g]),
          .key(req.trans_id), .entry(cell_entry[g]), .match(match_now[g])
        );
      end else begin : g_mid
        ptt_cell u_cell (
          .clk(clk), .ctrl(cell_ctrl[g]), .load_data(new_entry), .nbr(cell_entry[g+1]),
          .key(req.trans_id), .entry(cell_entry[g]), .match(match_now[g])
        );
      end
      assign live[g]           = OCC_W'(g) < occ;
      assign load_vec[g]       = do_post && (occ == OCC_W'(g));
      assign cell_ctrl[g].load  = load_vec[g];
      assign cell_ctrl[g].shift = shift_vec[g];
    end
  endgenerate

  always_comb begin
    first     = match_q & (~match_q + TABLE_DEPTH'(1));
    tail_mask = ~(first - TABLE_DEPTH'(1));
    found     = |match_q;
    sel_tag   = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      sel_tag = sel_tag | (first[k] ? cell_entry[k].tag : 16'd0);
    end
  end

  assign full      = (occ == OCC_W'(TABLE_DEPTH));
  assign diff0     = cell_entry[0].deadline - tick_count;
  assign diff1     = cell_entry[1].deadline - tick_count;
  assign exp0      = (occ != '0) && diff0[31];
  assign exp1      = (occ > OCC_W'(1)) && diff1[31];
  assign exp_last  = (exp_cnt == ptt_pkg::EXP_CNT_W'(ptt_pkg::MAX_RESULTS - 1)) || !exp1;
  assign out_free  = !rsp_valid || rsp.ready;
  assign do_post   = (state == ST_EMIT) && out_free && (act_q == ptt_pkg::ACT_POST) && !full;
  assign do_remove = (state == ST_EMIT) && out_free && (act_q == ptt_pkg::ACT_COMPLETE) && found;
  assign do_expire = (state == ST_EXPIRE) && out_free && exp0;
  assign shift_vec = do_expire ? '1 : (do_remove ? tail_mask : '0);
  assign rsp_load  = ((state == ST_EMIT) && out_free) || do_expire;

  assign new_entry.id       = id_q;
  assign new_entry.tag      = tag_q;
  assign new_entry.deadline = tick_count + {1'b0, timeout};

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occ        <= '0;
      tick_count <= '0;
      timeout    <= ptt_pkg::TIMEOUT_RESET;
      exp_cnt    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        timeout <= cfg.timeout_ticks;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            act_q   <= req.action;
            id_q    <= req.trans_id;
            tag_q   <= req.user_tag;
            pay_q   <= req.payload_ref;
            match_q <= match_now & live;
            unique case (req.action)
              ptt_pkg::ACT_POST, ptt_pkg::ACT_COMPLETE: begin
                state <= ST_EMIT;
              end
              ptt_pkg::ACT_TICK: begin
                tick_count <= tick_count + 32'd1;
                exp_cnt    <= '0;
                state      <= ST_EXPIRE;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            rsp.last   <= 1'b1;
            rsp.out_id <= id_q;
            state      <= ST_IDLE;
            if (act_q == ptt_pkg::ACT_POST) begin
              rsp.out_tag     <= tag_q;
              rsp.out_payload <= '0;
              rsp.has_payload <= 1'b0;
              if (full) begin
                rsp.status <= ptt_pkg::STATUS_FULL;
              end else begin
                rsp.status <= ptt_pkg::STATUS_POSTED;
                occ        <= occ + OCC_W'(1);
              end
            end else if (found) begin
              rsp.status      <= ptt_pkg::STATUS_COMPLETED;
              rsp.out_tag     <= sel_tag;
              rsp.out_payload <= pay_q;
              rsp.has_payload <= 1'b1;
              occ             <= occ - OCC_W'(1);
            end else begin
              rsp.status      <= ptt_pkg::STATUS_NOT_FOUND;
              rsp.out_tag     <= '0;
              rsp.out_payload <= '0;
              rsp.has_payload <= 1'b0;
            end
          end
        end
        ST_EXPIRE: begin
          if (!exp0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            rsp.status      <= ptt_pkg::STATUS_TIMED_OUT;
            rsp.out_id      <= cell_entry[0].id;
            rsp.out_tag     <= cell_entry[0].tag;
            rsp.out_payload <= '0;
            rsp.has_payload <= 1'b0;
            rsp.last        <= exp_last;
            occ             <= occ - OCC_W'(1);
            exp_cnt         <= exp_cnt + ptt_pkg::EXP_CNT_W'(1);
            if (exp_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/ptt_checker.sv
// Port-level checks of the pending transaction timeout table and their bind.
// Uses ptt_pkg; attached to pending_transaction_timeout_table_core.
module ptt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_action,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [31:0] rsp_out_id,
  input logic        rsp_has_payload,
  input logic        rsp_last
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_id) && $stable(rsp_status))
    else $error("Result changed while stalled.");

  a_post_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action == ptt_pkg::ACT_POST |=> !req_ready)
    else $error("Request taken while a post result is still being formed.");

  a_payload_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_has_payload |-> rsp_status == ptt_pkg::STATUS_COMPLETED)
    else $error("Payload flag on a result that is not a completion.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ptt_pkg::STATUS_TIMED_OUT |-> rsp_last)
    else $error("A post or complete result is not marked last.");

endmodule

bind pending_transaction_timeout_table_core ptt_checker u_ptt_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_action(req.action),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.status),
  .rsp_out_id(rsp.out_id),
  .rsp_has_payload(rsp.has_payload),
  .rsp_last(rsp.last)
);

>>> test/tb_pending_transaction_timeout_table_core.sv
// Self-checking testbench for pending_transaction_timeout_table_core: directed and random
// posts, completes and ticks under several timeout settings, with a predictor scoreboard.
// Depends on ptt_pkg, the ptt_req_if, ptt_rsp_if and ptt_cfg_if interfaces and the core.
module tb_pending_transaction_timeout_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ptt_pkg::DEFAULT_TABLE_DEPTH;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 38;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [15:0] tag;
    logic [31:0] payload;
    logic        has_payload;
    logic        last;
  } tracker_result_t;

  class txn_tracker_sb;
    logic [31:0] ids [DEPTH];
    logic [15:0] tags [DEPTH];
    logic [31:0] deadlines [DEPTH];
    int unsigned occupancy;
    logic [31:0] tick_now;
    logic [30:0] timeout;
    tracker_result_t expected_results[$];
    int unsigned requests;
    int unsigned errors;
    int unsigned status_seen [5];

    function new();
      occupancy = 0;
      tick_now = '0;
      timeout = ptt_pkg::TIMEOUT_RESET;
      requests = 0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_timeout(logic [30:0] value);
      timeout = value;
    endfunction

    function void add_result(logic [2:0] status, logic [31:0] id, logic [15:0] tag,
                             logic [31:0] payload, logic has_payload);
      tracker_result_t r;
      r.status = status;
      r.id = id;
      r.tag = tag;
      r.payload = payload;
      r.has_payload = has_payload;
      r.last = 1'b0;
      expected_results.push_back(r);
    endfunction

    function void remove_entry(int unsigned pos);
      for (int unsigned k = pos; k + 1 < occupancy; k++) begin
        ids[k] = ids[k + 1];
        tags[k] = tags[k + 1];
        deadlines[k] = deadlines[k + 1];
      end
      occupancy--;
    endfunction

    function void note_request(logic [1:0] action, logic [31:0] id, logic [15:0] tag,
                               logic [31:0] payload);
      int unsigned produced;
      bit found;
      logic [31:0] slack;
      tracker_result_t r;
      produced = 0;
      found = 0;
      requests++;
      case (action)
        ptt_pkg::ACT_POST: begin
          if (occupancy >= DEPTH) begin
            add_result(ptt_pkg::STATUS_FULL, id, tag, '0, 1'b0);
          end else begin
            ids[occupancy] = id;
            tags[occupancy] = tag;
            deadlines[occupancy] = tick_now + {1'b0, timeout};
            occupancy++;
            add_result(ptt_pkg::STATUS_POSTED, id, tag, '0, 1'b0);
          end
          produced = 1;
        end
        ptt_pkg::ACT_COMPLETE: begin
          for (int unsigned k = 0; k < occupancy && !found; k++) begin
            if (ids[k] == id) begin
              add_result(ptt_pkg::STATUS_COMPLETED, ids[k], tags[k], payload, 1'b1);
              remove_entry(k);
              found = 1;
            end
          end
          if (!found) add_result(ptt_pkg::STATUS_NOT_FOUND, id, '0, '0, 1'b0);
          produced = 1;
        end
        ptt_pkg::ACT_TICK: begin
          tick_now++;
          while (occupancy > 0 && produced < ptt_pkg::MAX_RESULTS) begin
            slack = deadlines[0] - tick_now;
            if (!slack[31]) break;
            add_result(ptt_pkg::STATUS_TIMED_OUT, ids[0], tags[0], '0, 1'b0);
            remove_entry(0);
            produced++;
          end
        end
        default: begin
        end
      endcase
      if (produced > 0) begin
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(tracker_result_t got);
      tracker_result_t want;
      if (got.status < 5) status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d id=%h tag=%h payload=%h hp=%b last=%b",
                 $time, got.status, got.id, got.tag, got.payload, got.has_payload, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch", $time);
        $display("%0t:   expected status=%0d id=%h tag=%h payload=%h hp=%b last=%b",
                 $time, want.status, want.id, want.tag, want.payload, want.has_payload,
                 want.last);
        $display("%0t:   actual   status=%0d id=%h tag=%h payload=%h hp=%b last=%b",
                 $time, got.status, got.id, got.tag, got.payload, got.has_payload,
                 got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit no_gaps;
  int idle_cycles = 0;
  int timeout_writes;
  logic [30:0] phase_timeouts [8];
  txn_tracker_sb sb = new();

  ptt_cfg_if cfg_ch();
  ptt_req_if req_ch();
  ptt_rsp_if rsp_ch();

  pending_transaction_timeout_table_core DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_timeout(cfg_ch.timeout_ticks);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.action, req_ch.trans_id, req_ch.user_tag, req_ch.payload_ref);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(tracker_result_t'({rsp_ch.status, rsp_ch.out_id, rsp_ch.out_tag,
                                           rsp_ch.out_payload, rsp_ch.has_payload,
                                           rsp_ch.last}));
    end
    if ((cfg_ch.valid && cfg_ch.ready) || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
    end
  end

  task automatic send_request(logic [1:0] action, logic [31:0] id, logic [15:0] tag,
                              logic [31:0] payload);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= action;
    req_ch.trans_id <= id;
    req_ch.user_tag <= tag;
    req_ch.payload_ref <= payload;
    do @(posedge clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [30:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.timeout_ticks <= value;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    cfg_ch.valid <= 1'b0;
    timeout_writes++;
  endtask

  task automatic random_request(output bit counted);
    int pick;
    logic [1:0] action;
    logic [31:0] id;
    logic [15:0] tag;
    logic [31:0] payload;
    pick = $urandom_range(0, 99);
    tag = 16'($urandom_range(0, 65535));
    payload = $urandom;
    id = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom;
    if (pick < 3) begin
      action = ACT_UNUSED;
    end else if (pick < 42) begin
      action = ptt_pkg::ACT_POST;
    end else if (pick < 72) begin
      action = ptt_pkg::ACT_COMPLETE;
      if (sb.occupancy > 0 && $urandom_range(0, 3) != 0)
        id = sb.ids[$urandom_range(0, sb.occupancy - 1)];
    end else begin
      action = ptt_pkg::ACT_TICK;
    end
    counted = (action != ACT_UNUSED);
    send_request(action, id, tag, payload);
  endtask

  initial begin
    int counted_items;
    bit counted;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= ptt_pkg::ACT_POST;
    req_ch.trans_id <= '0;
    req_ch.user_tag <= '0;
    req_ch.payload_ref <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.timeout_ticks <= '0;
    no_gaps = 0;
    timeout_writes = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Basic operations under the reset timeout, including a duplicate id.
    send_request(ptt_pkg::ACT_POST, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    send_request(ptt_pkg::ACT_POST, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ptt_pkg::ACT_POST, 32'hFFFF_FFFF, 16'h1234, 32'h0000_0000);
    send_request(ptt_pkg::ACT_COMPLETE, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
    send_request(ptt_pkg::ACT_COMPLETE, 32'h5555_AAAA, 16'hFFFF, 32'h0000_0000);
    send_request(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ptt_pkg::ACT_TICK, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    send_request(ptt_pkg::ACT_COMPLETE, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
    send_request(ptt_pkg::ACT_COMPLETE, 32'h0000_0000, 16'h0000, 32'hA5A5_5A5A);

    // With a zero timeout, fill the table, overflow it, then expire all entries at once.
    write_timeout(31'd0);
    for (int i = 0; i <= DEPTH; i++)
      send_request(ptt_pkg::ACT_POST, $urandom, 16'(i), $urandom);
    send_request(ptt_pkg::ACT_TICK, $urandom, 16'h0000, 32'h0000_0000);

    phase_timeouts = '{31'h7FFF_FFFF, 31'd1, 31'd3, 31'd0, 31'd6, 31'd2, 31'd12, 31'd0};
    phase_timeouts[7] = 31'($urandom_range(0, 20));
    foreach (phase_timeouts[p]) begin
      write_timeout(phase_timeouts[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) counted_items++;
      end
    end
    no_gaps = 0;

    settle();
    $display("Sent %0d requests across %0d timeout settings.", sb.requests, timeout_writes);
    $display("Results: %0d posted, %0d full, %0d completed, %0d not found, %0d timed out.",
             sb.status_seen[ptt_pkg::STATUS_POSTED], sb.status_seen[ptt_pkg::STATUS_FULL],
             sb.status_seen[ptt_pkg::STATUS_COMPLETED],
             sb.status_seen[ptt_pkg::STATUS_NOT_FOUND],
             sb.status_seen[ptt_pkg::STATUS_TIMED_OUT]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
